// ----- hdl/qade_pkg.sv -----
// Shared types, codes and constants for the QR alphanumeric data encoder.
// Used by qade_ctrl, qade_dpath and the top level; depends on nothing.
package qade_pkg;

    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 8;

    localparam logic [1:0] EMIT_NONE = 2'd0;
    localparam logic [1:0] EMIT_DATA = 2'd1;
    localparam logic [1:0] EMIT_PAD  = 2'd2;
    localparam logic [1:0] EMIT_ERR  = 2'd3;

    localparam logic [1:0] ERR_NONE     = 2'd0;
    localparam logic [1:0] ERR_INVALID  = 2'd1;
    localparam logic [1:0] ERR_CAPACITY = 2'd2;

    localparam logic CFG_VERSION   = 1'b0;
    localparam logic CFG_CODEWORDS = 1'b1;

    localparam logic [3:0] MODE_IND = 4'b0010;
    localparam logic [7:0] PAD_A    = 8'hEC;
    localparam logic [7:0] PAD_B    = 8'h11;

    localparam logic [5:0] VERSION_RESET   = 6'd1;
    localparam logic [6:0] CODEWORDS_RESET = 7'd13;

    typedef struct packed {
        logic       load;
        logic       exec;
        logic       term;
        logic       clear;
        logic [1:0] emit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic skip;
        logic err;
        logic finishing;
        logic fill_ge8;
        logic fill_nz;
        logic bytes_lt_cap;
        logic out_free;
    } ctrl_stat_t;

    // Returns {valid, value}; valid is low for a character outside the set.
    function automatic logic [6:0] char_value(input logic [7:0] c);
        logic [6:0] v;
        v = 7'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            v = {1'b1, 6'(c - 8'h30)};
        end else if (c >= 8'h41 && c <= 8'h5A) begin
            v = {1'b1, 6'(c - 8'h37)};
        end else begin
            case (c)
                8'h20:   v = {1'b1, 6'd36};
                8'h24:   v = {1'b1, 6'd37};
                8'h25:   v = {1'b1, 6'd38};
                8'h2A:   v = {1'b1, 6'd39};
                8'h2B:   v = {1'b1, 6'd40};
                8'h2D:   v = {1'b1, 6'd41};
                8'h2E:   v = {1'b1, 6'd42};
                8'h2F:   v = {1'b1, 6'd43};
                8'h3A:   v = {1'b1, 6'd44};
                default: v = 7'd0;
            endcase
        end
        return v;
    endfunction

endpackage

// ----- hdl/qr_alphanumeric_data_encoder.sv -----
// QR alphanumeric data encoder. A request is taken when idle and evaluated in
// the next cycle; each codeword then leaves through the output register.
// After a start or character request every whole byte in the accumulator is sent.
// A final item also sends the terminator, the last bits and pad codewords up to data_codewords.
// Reset (synchronous, active low) ends any message and sets version 1, 13 codewords.
module qr_alphanumeric_data_encoder #(
    parameter int MAX_CODEWORDS = 64
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // [12:0] message_length, [20:13] char_code, [23:21] zero
    input  logic [qade_pkg::S_TDATA_W-1:0] s_tdata,
    // [0] func
    input  logic                           s_tuser,
    input  logic                           s_tlast,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [7:0] out_byte
    output logic [qade_pkg::M_TDATA_W-1:0] m_tdata,
    // [1:0] error_code
    output logic [1:0]                     m_tuser,
    output logic                           m_tlast,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic                           cfg_addr,
    input  logic [6:0]                     cfg_data
);
    import qade_pkg::*;

    ctrl_cmd_t  cmd;
    ctrl_stat_t stat;

    assign cfg_ready = 1'b1;

    qade_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    qade_dpath #(
        .MAX_CODEWORDS (MAX_CODEWORDS)
    ) u_dpath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .stat      (stat),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .cfg_valid (cfg_valid),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

endmodule

// ----- hdl/qade_ctrl.sv -----
// Sequencing state machine of the QR alphanumeric data encoder.
// Drives datapath commands from its status; uses qade_pkg.
module qade_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  qade_pkg::ctrl_stat_t  stat,
    output qade_pkg::ctrl_cmd_t   cmd
);
    import qade_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_EXEC  = 3'd1;
    localparam logic [2:0] ST_FLUSH = 3'd2;
    localparam logic [2:0] ST_TERM  = 3'd3;
    localparam logic [2:0] ST_FINAL = 3'd4;
    localparam logic [2:0] ST_PAD   = 3'd5;
    localparam logic [2:0] ST_ERR   = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd.load   = 1'b0;
        cmd.exec   = 1'b0;
        cmd.term   = 1'b0;
        cmd.clear  = 1'b0;
        cmd.emit   = EMIT_NONE;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                cmd.exec = 1'b1;
                if (stat.skip) begin
                    state_next = ST_IDLE;
                end else if (stat.err) begin
                    state_next = ST_ERR;
                end else begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                if (stat.fill_ge8) begin
                    if (stat.out_free) begin
                        cmd.emit = EMIT_DATA;
                    end
                end else if (stat.finishing) begin
                    state_next = ST_TERM;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_TERM: begin
                cmd.term   = 1'b1;
                state_next = ST_FINAL;
            end
            ST_FINAL: begin
                if (stat.fill_nz) begin
                    if (stat.out_free) begin
                        cmd.emit = EMIT_DATA;
                    end
                end else begin
                    state_next = ST_PAD;
                end
            end
            ST_PAD: begin
                if (stat.bytes_lt_cap) begin
                    if (stat.out_free) begin
                        cmd.emit = EMIT_PAD;
                    end
                end else begin
                    cmd.clear  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_ERR: begin
                if (stat.out_free) begin
                    cmd.emit   = EMIT_ERR;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign s_tready = (state_reg == ST_IDLE);

endmodule

// ----- hdl/qade_dpath.sv -----
// Datapath of the QR alphanumeric data encoder: request and configuration
// registers, bit accumulator, byte counter and capacity checks, output register.
// Uses qade_pkg; commanded by qade_ctrl.
module qade_dpath #(
    parameter int MAX_CODEWORDS = 64
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  qade_pkg::ctrl_cmd_t               cmd,
    output qade_pkg::ctrl_stat_t              stat,
    input  logic [qade_pkg::S_TDATA_W-1:0]    s_tdata,
    input  logic                              s_tuser,
    input  logic                              s_tlast,
    input  logic                              cfg_valid,
    input  logic                              cfg_addr,
    input  logic [6:0]                        cfg_data,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [qade_pkg::M_TDATA_W-1:0]    m_tdata,
    output logic                              m_tlast,
    output logic [1:0]                        m_tuser
);
    import qade_pkg::*;

    localparam int CAP_W = $clog2(MAX_CODEWORDS + 1);
    localparam int CMP_W = (CAP_W > 7) ? CAP_W : 7;
    localparam int BIT_W = CAP_W + 4;

    logic             func_reg;
    logic [12:0]      len_reg;
    logic [7:0]       char_reg;
    logic             lastc_reg;
    logic [5:0]       version_reg, version_next;
    logic [6:0]       codewords_reg, codewords_next;
    logic [23:0]      acc_reg, acc_next;
    logic [4:0]       fill_reg, fill_next;
    logic [CAP_W-1:0] bytes_reg, bytes_next;
    logic [5:0]       pend_val_reg, pend_val_next;
    logic             pend_vld_reg, pend_vld_next;
    logic             active_reg, active_next;
    logic             finish_reg, finish_next;
    logic             pad_sel_reg, pad_sel_next;
    logic [1:0]       err_code_reg, err_code_next;
    logic             out_vld_reg, out_vld_next;
    logic [7:0]       out_byte_reg, out_byte_next;
    logic             out_last_reg, out_last_next;
    logic [1:0]       out_err_reg, out_err_next;

    logic [CMP_W-1:0] cap_wide;
    logic [CAP_W-1:0] cap;
    logic [BIT_W-1:0] cap_bits;
    logic [BIT_W-1:0] used_bits;
    logic [BIT_W-1:0] room;
    logic [2:0]       term_n;
    logic [23:0]      hdr;
    logic [4:0]       hdr_len;
    logic [6:0]       cval;
    logic [10:0]      pair_val;
    logic [4:0]       char_need;
    logic             fits_start;
    logic             fits_char;
    logic [31:0]      byte_sh;
    logic             last_hit;
    logic             out_free;

    assign cap_wide = (CMP_W'(codewords_reg) < CMP_W'(MAX_CODEWORDS)) ?
                      CMP_W'(codewords_reg) : CMP_W'(MAX_CODEWORDS);
    assign cap       = cap_wide[CAP_W-1:0];
    assign cap_bits  = {1'b0, cap, 3'b000};
    assign used_bits = {1'b0, bytes_reg, 3'b000} + BIT_W'(fill_reg);
    assign room      = cap_bits - used_bits;
    assign term_n    = (room >= BIT_W'(4)) ? 3'd4 : room[2:0];

    always_comb begin
        if (version_reg <= 6'd9) begin
            hdr     = {11'd0, MODE_IND, len_reg[8:0]};
            hdr_len = 5'd13;
        end else if (version_reg <= 6'd26) begin
            hdr     = {9'd0, MODE_IND, len_reg[10:0]};
            hdr_len = 5'd15;
        end else begin
            hdr     = {7'd0, MODE_IND, len_reg[12:0]};
            hdr_len = 5'd17;
        end
    end

    assign cval      = char_value(char_reg);
    assign pair_val  = 11'(11'(pend_val_reg) * 11'd45) + 11'(cval[5:0]);
    assign char_need = pend_vld_reg ? 5'd11 : (lastc_reg ? 5'd6 : 5'd0);
    assign fits_start = BIT_W'(hdr_len) <= cap_bits;
    assign fits_char  = (used_bits + BIT_W'(char_need)) <= cap_bits;

    assign byte_sh  = {acc_reg, 8'h00} >> fill_reg;
    assign last_hit = finish_reg &&
                      (((CAP_W + 1)'(bytes_reg) + (CAP_W + 1)'(1)) == (CAP_W + 1)'(cap));
    assign out_free = !out_vld_reg || m_tready;

    assign stat.skip         = func_reg && !active_reg;
    assign stat.err          = func_reg ? (!cval[6] || !fits_char) : !fits_start;
    assign stat.finishing    = finish_reg;
    assign stat.fill_ge8     = fill_reg >= 5'd8;
    assign stat.fill_nz      = fill_reg != 5'd0;
    assign stat.bytes_lt_cap = bytes_reg < cap;
    assign stat.out_free     = out_free;

    always_comb begin
        version_next   = version_reg;
        codewords_next = codewords_reg;
        acc_next       = acc_reg;
        fill_next      = fill_reg;
        bytes_next     = bytes_reg;
        pend_val_next  = pend_val_reg;
        pend_vld_next  = pend_vld_reg;
        active_next    = active_reg;
        finish_next    = finish_reg;
        pad_sel_next   = pad_sel_reg;
        err_code_next  = err_code_reg;
        out_vld_next   = out_vld_reg && !m_tready;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;
        out_err_next   = out_err_reg;

        if (cfg_valid) begin
            if (cfg_addr == CFG_VERSION) begin
                version_next = cfg_data[5:0];
            end else begin
                codewords_next = cfg_data;
            end
        end

        if (cmd.exec) begin
            if (!func_reg) begin
                pend_val_next = 6'd0;
                pend_vld_next = 1'b0;
                bytes_next    = '0;
                pad_sel_next  = 1'b0;
                active_next   = 1'b1;
                finish_next   = (len_reg == 13'd0);
                if (fits_start) begin
                    acc_next  = hdr;
                    fill_next = hdr_len;
                end else begin
                    fill_next     = 5'd0;
                    err_code_next = ERR_CAPACITY;
                end
            end else if (active_reg) begin
                if (!cval[6]) begin
                    err_code_next = ERR_INVALID;
                end else if (!fits_char) begin
                    err_code_next = ERR_CAPACITY;
                end else begin
                    if (pend_vld_reg) begin
                        acc_next      = (acc_reg << 11) | 24'(pair_val);
                        pend_vld_next = 1'b0;
                        pend_val_next = 6'd0;
                    end else if (lastc_reg) begin
                        acc_next = (acc_reg << 6) | 24'(cval[5:0]);
                    end else begin
                        pend_val_next = cval[5:0];
                        pend_vld_next = 1'b1;
                    end
                    fill_next   = fill_reg + char_need;
                    finish_next = lastc_reg;
                end
            end
        end

        if (cmd.term) begin
            acc_next  = acc_reg << term_n;
            fill_next = fill_reg + 5'(term_n);
        end

        case (cmd.emit)
            EMIT_DATA: begin
                out_vld_next  = 1'b1;
                out_byte_next = byte_sh[7:0];
                out_last_next = last_hit;
                out_err_next  = ERR_NONE;
                fill_next     = (fill_reg >= 5'd8) ? (fill_reg - 5'd8) : 5'd0;
                bytes_next    = bytes_reg + CAP_W'(1);
            end
            EMIT_PAD: begin
                out_vld_next  = 1'b1;
                out_byte_next = pad_sel_reg ? PAD_B : PAD_A;
                out_last_next = last_hit;
                out_err_next  = ERR_NONE;
                pad_sel_next  = !pad_sel_reg;
                bytes_next    = bytes_reg + CAP_W'(1);
            end
            EMIT_ERR: begin
                out_vld_next  = 1'b1;
                out_byte_next = 8'h00;
                out_last_next = 1'b1;
                out_err_next  = err_code_reg;
            end
            default: begin
            end
        endcase

        if (cmd.clear || (cmd.emit == EMIT_ERR)) begin
            fill_next     = 5'd0;
            bytes_next    = '0;
            pend_val_next = 6'd0;
            pend_vld_next = 1'b0;
            active_next   = 1'b0;
            finish_next   = 1'b0;
            pad_sel_next  = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            version_reg   <= VERSION_RESET;
            codewords_reg <= CODEWORDS_RESET;
            fill_reg      <= 5'd0;
            bytes_reg     <= '0;
            pend_vld_reg  <= 1'b0;
            active_reg    <= 1'b0;
            finish_reg    <= 1'b0;
            pad_sel_reg   <= 1'b0;
            out_vld_reg   <= 1'b0;
        end else begin
            version_reg   <= version_next;
            codewords_reg <= codewords_next;
            fill_reg      <= fill_next;
            bytes_reg     <= bytes_next;
            pend_vld_reg  <= pend_vld_next;
            active_reg    <= active_next;
            finish_reg    <= finish_next;
            pad_sel_reg   <= pad_sel_next;
            out_vld_reg   <= out_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            func_reg  <= s_tuser;
            len_reg   <= s_tdata[12:0];
            char_reg  <= s_tdata[20:13];
            lastc_reg <= s_tlast;
        end
        acc_reg      <= acc_next;
        pend_val_reg <= pend_val_next;
        err_code_reg <= err_code_next;
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
        out_err_reg  <= out_err_next;
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_err_reg;

    a_fill_range: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= 5'd20)
        else $error("bit accumulator fill out of range");

    a_emit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.emit != EMIT_NONE) |-> out_free)
        else $error("byte emitted into a busy output register");

    a_err_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser != ERR_NONE)) |-> (m_tlast && (m_tdata == 8'h00)))
        else $error("error result without last flag or with nonzero data");

    a_err_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.emit == EMIT_ERR) |=> (!active_reg && (fill_reg == 5'd0)))
        else $error("message state not cleared after error");

endmodule
